>>> design/kufe_pkg.sv
// Shared constants for the spanning-tree union-find engine.
`timescale 1ns / 1ps
`default_nettype none
package kufe_pkg;

   localparam int NODES    = 1024;
   localparam int NODE_W   = $clog2(NODES);
   localparam int CNT_W    = 11;
   localparam int WEIGHT_W = 32;
   localparam int SUM_W    = 48;
   localparam int REQ_DATA_W = 56;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_EDGE  = 1'b1;

   localparam logic SIDE_A = 1'b0;
   localparam logic SIDE_B = 1'b1;

endpackage
`default_nettype wire

>>> design/kufe_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
`timescale 1ns / 1ps
`default_nettype none
module kufe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> design/kruskal_union_find_engine.sv
// Top level of the Kruskal spanning-tree union-find engine.
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Direction | Contents
// ----------+-----------+----------------------------------------------------
// req_*     | in        | tuser=operation, tdata=node_a,node_b,weight, tlast=last_edge
// rsp_*     | out       | tuser=merged, tdata=total, tlast=final_res
// csr_*     | in        | node_count write (11 bits)
//
// Sequence: an edge walks from each endpoint to its root in the parent RAM
// (one read per step, then one read/write step per compressed node), links
// the two roots and registers the result; the engine then returns to idle
// and takes the next transaction.
// A clear transaction sweeps the parent RAM, one entry a cycle, then gives a result.
// Reset: a clearing pass over all 1024 entries follows reset; no transaction is accepted
// until it ends. An output register holds the last result while rsp_tready is
// low; a new transaction is still accepted, and its result waits until taken.
module kruskal_union_find_engine
   import kufe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // node_a[9:0], node_b[19:10], weight[51:20], 0
   input  wire logic                  req_tuser,  // operation
   input  wire logic                  req_tlast,  // last_edge
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [SUM_W-1:0]      rsp_tdata,  // total[47:0]
   output logic                       rsp_tuser,  // merged
   output logic                       rsp_tlast,  // final_res
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CNT_W-1:0]      csr_wr_data // node_count
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_COMP,
      S_LINK,
      S_DONE
   } state_type;

   // control
   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    cnt_ff, cnt_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic                 side_ff, side_in;
   logic [CNT_W-1:0]     node_count_ff;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   // payload
   logic [NODE_W-1:0]    a_ff, a_in;
   logic [NODE_W-1:0]    b_ff, b_in;
   logic [NODE_W-1:0]    cur_ff, cur_in;
   logic [NODE_W-1:0]    root_ff, root_in;
   logic [NODE_W-1:0]    root_a_ff, root_a_in;
   logic [WEIGHT_W-1:0]  weight_ff, weight_in;
   logic                 last_ff, last_in;
   logic                 merged_ff, merged_in;
   logic [SUM_W-1:0]     rsp_total_ff, rsp_total_in;
   logic                 rsp_merged_ff, rsp_merged_in;
   logic                 rsp_last_ff, rsp_last_in;

   // parent RAM port signals
   logic                 ram_we;
   logic [NODE_W-1:0]    ram_waddr;
   logic [NODE_W-1:0]    ram_wdata;
   logic                 ram_re;
   logic [NODE_W-1:0]    ram_raddr;
   logic [NODE_W-1:0]    ram_rdata;

   logic [NODE_W-1:0]    req_a;
   logic [NODE_W-1:0]    req_b;
   logic [WEIGHT_W-1:0]  req_weight;
   logic [CNT_W-1:0]     limit;
   logic                 in_range;
   logic                 root_done;
   logic [NODE_W-1:0]    root_val;
   logic [NODE_W-1:0]    start_node;
   logic [SUM_W:0]       sum_wide;

   kufe_ram #(
      .WIDTH (NODE_W),
      .DEPTH (NODES)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_a      = req_tdata[NODE_W-1:0];
   assign req_b      = req_tdata[2*NODE_W-1:NODE_W];
   assign req_weight = req_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];

   // node_count above the table size acts as the table size
   assign limit    = (node_count_ff > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_ff;
   assign in_range = (CNT_W'(req_a) < limit) && (CNT_W'(req_b) < limit);

   assign start_node = (side_ff == SIDE_B) ? b_ff : a_ff;
   assign sum_wide   = {1'b0, sum_ff} + (SUM_W + 1)'(weight_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_total_ff;
   assign rsp_tuser  = rsp_merged_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      side_in       = side_ff;
      sum_in        = sum_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;
      root_in       = root_ff;
      root_a_in     = root_a_ff;
      weight_in     = weight_ff;
      last_in       = last_ff;
      merged_in     = merged_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff;
      ram_wdata     = root_ff;
      ram_re        = 1'b0;
      ram_raddr     = cur_ff;
      root_done     = 1'b0;
      root_val      = root_ff;

      case (state_ff)
         S_CLEAR: begin
            // sweep: every node points to itself
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == NODE_W'(NODES - 1)) begin
               sum_in    = '0;
               merged_in = 1'b0;
               state_in  = clr_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               a_in      = req_a;
               b_in      = req_b;
               weight_in = req_weight;
               merged_in = 1'b0;
               side_in   = SIDE_A;
               if (req_tuser == OP_CLEAR) begin
                  last_in    = 1'b0;
                  cnt_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLEAR;
               end else if (in_range) begin
                  last_in   = req_tlast;
                  cur_in    = req_a;
                  ram_re    = 1'b1;
                  ram_raddr = req_a;
                  state_in  = S_WALK;
               end else begin
                  // endpoint outside the graph: drop the edge
                  last_in  = req_tlast;
                  state_in = S_DONE;
               end
            end
         end
         S_WALK: begin
            // ram_rdata is the parent of cur_ff
            if (ram_rdata == cur_ff) begin
               root_in = cur_ff;
               if (start_node == cur_ff) begin
                  root_done = 1'b1;
                  root_val  = cur_ff;
               end else begin
                  // second pass: point every node on the path at the root
                  cur_in    = start_node;
                  ram_re    = 1'b1;
                  ram_raddr = start_node;
                  state_in  = S_COMP;
               end
            end else begin
               cur_in    = ram_rdata;
               ram_re    = 1'b1;
               ram_raddr = ram_rdata;
            end
         end
         S_COMP: begin
            ram_we    = 1'b1;
            ram_waddr = cur_ff;
            ram_wdata = root_ff;
            if (ram_rdata == root_ff) begin
               root_done = 1'b1;
               root_val  = root_ff;
            end else begin
               cur_in    = ram_rdata;
               ram_re    = 1'b1;
               ram_raddr = ram_rdata;
            end
         end
         S_LINK: begin
            // larger root goes under the smaller one
            if (root_a_ff != root_ff) begin
               ram_we    = 1'b1;
               ram_waddr = (root_a_ff > root_ff) ? root_a_ff : root_ff;
               ram_wdata = (root_a_ff > root_ff) ? root_ff : root_a_ff;
               merged_in = 1'b1;
               sum_in    = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_total_in  = sum_ff;
               rsp_merged_in = merged_ff;
               rsp_last_in   = last_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // one endpoint resolved: start on the other, or go link
      if (root_done) begin
         if (side_ff == SIDE_A) begin
            root_a_in = root_val;
            side_in   = SIDE_B;
            cur_in    = b_ff;
            ram_re    = 1'b1;
            ram_raddr = b_ff;
            state_in  = S_WALK;
         end else begin
            root_in  = root_val;
            state_in = S_LINK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         side_ff       <= SIDE_A;
         sum_ff        <= '0;
         node_count_ff <= CNT_W'(NODES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         clr_rsp_ff    <= clr_rsp_in;
         side_ff       <= side_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            node_count_ff <= csr_wr_data;
         end
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      cur_ff        <= cur_in;
      root_ff       <= root_in;
      root_a_ff     <= root_a_in;
      weight_ff     <= weight_in;
      last_ff       <= last_in;
      merged_ff     <= merged_in;
      rsp_total_ff  <= rsp_total_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // a parent never has a larger index than its child
   a_walk_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (ram_rdata <= cur_ff))
      else $error("parent table entry points above its own index");

   // a link always hangs the larger root under the smaller one
   a_link_order: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_LINK) |-> (ram_wdata < ram_waddr))
      else $error("link writes a parent above the child");

   // the running total only drops at the end of a clearing pass
   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      (!reset && state_ff != S_CLEAR) |=> (sum_ff >= $past(sum_ff)))
      else $error("running total decreased outside a clear");

endmodule
`default_nettype wire
